// ===== rtl/swms_pkg.sv =====
// Shared types and constants of the sliding window mean/max statistics block.
// No dependencies; every other file imports this package.
`default_nettype none

package swms_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int WINDOW_MAX = 64;
  localparam int NUM_CH     = 4;
  localparam int NUM_MEAN   = 2;
  localparam int CNT_W      = 7;
  localparam int PTR_W      = $clog2(WINDOW_MAX);
  localparam int SUM_W      = SAMPLE_W + PTR_W;
  localparam int PEAK_W     = SAMPLE_W - 1;
  localparam int DIV_STEPS  = SUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int REM_W      = CNT_W + 1;
  localparam int WORD_W     = NUM_CH * SAMPLE_W;

  localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(WINDOW_MAX);

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [SUM_W-1:0]           quo_t;
  typedef logic [REM_W-1:0]           rem_t;
  typedef logic [PEAK_W-1:0]          peak_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_WALK,
    ST_TAIL,
    ST_DIV_INIT,
    ST_DIV,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic capture;
    logic write;
    logic walk_issue;
    logic div_init;
    logic div_step;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic walk_last;
    logic div_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/swms_in_if.sv =====
// Input channel of the statistics block: valid/ready plus one sample word.
// Depends on swms_pkg.
`default_nettype none

interface swms_in_if
  import swms_pkg::*;
;
  logic    valid;
  logic    ready;
  logic    opcode;
  sample_t sample_a;
  sample_t sample_b;
  sample_t sample_c;
  sample_t sample_d;

  modport source (output valid, output opcode, output sample_a, output sample_b,
                  output sample_c, output sample_d, input ready);
  modport sink   (input valid, input opcode, input sample_a, input sample_b,
                  input sample_c, input sample_d, output ready);
endinterface

`default_nettype wire

// ===== rtl/swms_out_if.sv =====
// Result channel of the statistics block: valid/ready plus one statistics word.
// Depends on swms_pkg.
`default_nettype none

interface swms_out_if
  import swms_pkg::*;
;
  logic             valid;
  logic             ready;
  sample_t          mean_a;
  sample_t          mean_b;
  peak_t            peak_a;
  peak_t            peak_b;
  peak_t            peak_c;
  peak_t            peak_d;
  sample_t          latest_a;
  sample_t          latest_b;
  sample_t          latest_c;
  sample_t          latest_d;
  logic [CNT_W-1:0] fill_count;

  modport source (output valid, output mean_a, output mean_b, output peak_a,
                  output peak_b, output peak_c, output peak_d, output latest_a,
                  output latest_b, output latest_c, output latest_d,
                  output fill_count, input ready);
  modport sink   (input valid, input mean_a, input mean_b, input peak_a,
                  input peak_b, input peak_c, input peak_d, input latest_a,
                  input latest_b, input latest_c, input latest_d,
                  input fill_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/swms_ctrl.sv =====
// Sequencer of the statistics block: walks write, ring walk, divide and load.
// Depends on swms_pkg; drives swms_dp through dp_cmd_t, reads dp_stat_t.
`default_nettype none

module swms_ctrl
  import swms_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (stat.is_clear) begin
          state_nxt = ST_LOAD;
        end else begin
          cmd.write = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk_issue = 1'b1;
        if (stat.walk_last) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_nxt = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!out_valid_r || out_ready) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.load | (out_valid_r & ~out_ready);
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/swms_dp.sv =====
// Datapath of the statistics block: sample ring, accumulators, two-lane divider,
// output word register and the window length register. Depends on swms_pkg.
`default_nettype none

module swms_dp
  import swms_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire dp_cmd_t          cmd,
  output dp_stat_t              stat,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  input  wire logic             in_opcode,
  input  wire sample_t          in_smp [NUM_CH],
  output sample_t               o_mean [NUM_MEAN],
  output peak_t                 o_peak [NUM_CH],
  output sample_t               o_latest [NUM_CH],
  output logic [CNT_W-1:0]      o_fill
);

  logic [WORD_W-1:0] ring_mem [WINDOW_MAX];

  logic                 op_r;
  sample_t              cur_r [NUM_CH];
  logic [PTR_W-1:0]     wp_r, wp_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     wlen_r;
  logic [CNT_W-1:0]     len_eff;
  logic [CNT_W-1:0]     idx_r;
  logic [PTR_W-1:0]     rd_addr;
  logic                 rd_vld_r;
  logic [WORD_W-1:0]    rd_data_r;
  logic [WORD_W-1:0]    wr_word;
  sum_t                 sum_r [NUM_MEAN];
  sample_t              peak_r [NUM_CH];
  quo_t                 quo_r [NUM_MEAN], quo_nxt [NUM_MEAN];
  rem_t                 rem_r [NUM_MEAN], rem_nxt [NUM_MEAN];
  logic                 neg_r [NUM_MEAN];
  logic [DIV_CNT_W-1:0] div_cnt_r;
  rem_t                 divisor;
  rem_t                 rem_sh;
  sample_t              rd_smp [NUM_CH];
  sample_t              mean_r [NUM_MEAN];
  peak_t                peak_out_r [NUM_CH];
  sample_t              latest_r [NUM_CH];
  logic [CNT_W-1:0]     fill_r;

  always_comb begin
    priority if (wlen_r == '0) begin
      len_eff = CNT_W'(1);
    end else if (wlen_r > CNT_W'(WINDOW_MAX)) begin
      len_eff = CNT_W'(WINDOW_MAX);
    end else begin
      len_eff = wlen_r;
    end
  end

  always_comb begin
    wp_nxt  = wp_r;
    cnt_nxt = cnt_r;
    if (cmd.write) begin
      wp_nxt  = wp_r + PTR_W'(1);
      cnt_nxt = (cnt_r < len_eff) ? cnt_r + CNT_W'(1) : len_eff;
    end else if (cmd.load && op_r == OP_CLEAR) begin
      wp_nxt  = '0;
      cnt_nxt = '0;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      wr_word[c*SAMPLE_W +: SAMPLE_W] = cur_r[c];
      rd_smp[c] = sample_t'(rd_data_r[c*SAMPLE_W +: SAMPLE_W]);
    end
  end

  assign rd_addr = wp_r - PTR_W'(1) - idx_r[PTR_W-1:0];
  assign divisor = REM_W'(cnt_r);

  always_comb begin
    rem_sh = '0;
    for (int m = 0; m < NUM_MEAN; m++) begin
      rem_sh     = {rem_r[m][REM_W-2:0], quo_r[m][SUM_W-1]};
      quo_nxt[m] = {quo_r[m][SUM_W-2:0], 1'b0};
      rem_nxt[m] = rem_sh;
      if (rem_sh >= divisor) begin
        rem_nxt[m]    = rem_sh - divisor;
        quo_nxt[m][0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      ring_mem[wp_r] <= wr_word;
    end
    rd_data_r <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      cnt_r    <= '0;
      wlen_r   <= WINDOW_RESET;
      rd_vld_r <= 1'b0;
    end else begin
      wp_r     <= wp_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= cmd.walk_issue;
      if (cfg_we) begin
        wlen_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_opcode;
      for (int c = 0; c < NUM_CH; c++) begin
        cur_r[c] <= in_smp[c];
      end
    end
    if (cmd.write) begin
      idx_r <= '0;
      for (int m = 0; m < NUM_MEAN; m++) begin
        sum_r[m] <= '0;
      end
      for (int c = 0; c < NUM_CH; c++) begin
        peak_r[c] <= '0;
      end
    end else begin
      if (cmd.walk_issue) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (rd_vld_r) begin
        for (int m = 0; m < NUM_MEAN; m++) begin
          sum_r[m] <= sum_r[m] + SUM_W'(rd_smp[m]);
        end
        for (int c = 0; c < NUM_CH; c++) begin
          if (rd_smp[c] > peak_r[c]) begin
            peak_r[c] <= rd_smp[c];
          end
        end
      end
    end
    if (cmd.div_init) begin
      div_cnt_r <= '0;
      for (int m = 0; m < NUM_MEAN; m++) begin
        neg_r[m] <= sum_r[m][SUM_W-1];
        quo_r[m] <= sum_r[m][SUM_W-1] ? quo_t'(-sum_r[m]) : quo_t'(sum_r[m]);
        rem_r[m] <= '0;
      end
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      for (int m = 0; m < NUM_MEAN; m++) begin
        quo_r[m] <= quo_nxt[m];
        rem_r[m] <= rem_nxt[m];
      end
    end
    if (cmd.load) begin
      if (op_r == OP_CLEAR) begin
        fill_r <= '0;
        for (int m = 0; m < NUM_MEAN; m++) begin
          mean_r[m] <= '0;
        end
        for (int c = 0; c < NUM_CH; c++) begin
          peak_out_r[c] <= '0;
          latest_r[c]   <= '0;
        end
      end else begin
        fill_r <= cnt_r;
        for (int m = 0; m < NUM_MEAN; m++) begin
          mean_r[m] <= neg_r[m] ? sample_t'(-quo_r[m][SAMPLE_W-1:0])
                                : sample_t'(quo_r[m][SAMPLE_W-1:0]);
        end
        for (int c = 0; c < NUM_CH; c++) begin
          peak_out_r[c] <= peak_r[c][PEAK_W-1:0];
          latest_r[c]   <= cur_r[c];
        end
      end
    end
  end

  assign stat.is_clear  = (op_r == OP_CLEAR);
  assign stat.walk_last = (idx_r == cnt_r - CNT_W'(1));
  assign stat.div_last  = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  assign o_mean   = mean_r;
  assign o_peak   = peak_out_r;
  assign o_latest = latest_r;
  assign o_fill   = fill_r;

endmodule

`default_nettype wire

// ===== rtl/sliding_window_mean_max_stats.sv =====
// Top level of the sliding window mean/max statistics block.
// Depends on swms_pkg, swms_in_if, swms_out_if, swms_ctrl and swms_dp.
//
//   port     | direction | handshake       | word
//   ---------+-----------+-----------------+-------------------------------------
//   in_if    | sink      | valid / ready   | opcode, sample_a..sample_d
//   out_if   | source    | valid / ready   | mean_a/b, peak_a..d, latest_a..d,
//            |           |                 | fill_count
//   cfg_*    | input     | cfg_we          | cfg_wdata = window_len
//
// A record passes from accept to result through the serial ring walk (one entry per
// cycle) and the 22-step two-lane divider; a clear skips both. One word is in flight;
// the next is accepted while the previous result still waits in the output register.
// rst_n is synchronous, active low; it empties the window and sets window_len to 64.
// A stalled result holds the block in its load state until out_if.ready.
`default_nettype none

module sliding_window_mean_max_stats
  import swms_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  swms_in_if.sink               in_if,
  swms_out_if.source            out_if,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  sample_t          in_smp [NUM_CH];
  sample_t          o_mean [NUM_MEAN];
  peak_t            o_peak [NUM_CH];
  sample_t          o_latest [NUM_CH];
  logic [CNT_W-1:0] o_fill;

  assign in_smp[0] = in_if.sample_a;
  assign in_smp[1] = in_if.sample_b;
  assign in_smp[2] = in_if.sample_c;
  assign in_smp[3] = in_if.sample_d;

  swms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  swms_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_opcode (in_if.opcode),
    .in_smp    (in_smp),
    .o_mean    (o_mean),
    .o_peak    (o_peak),
    .o_latest  (o_latest),
    .o_fill    (o_fill)
  );

  assign out_if.mean_a     = o_mean[0];
  assign out_if.mean_b     = o_mean[1];
  assign out_if.peak_a     = o_peak[0];
  assign out_if.peak_b     = o_peak[1];
  assign out_if.peak_c     = o_peak[2];
  assign out_if.peak_d     = o_peak[3];
  assign out_if.latest_a   = o_latest[0];
  assign out_if.latest_b   = o_latest[1];
  assign out_if.latest_c   = o_latest[2];
  assign out_if.latest_d   = o_latest[3];
  assign out_if.fill_count = o_fill;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for sliding_window_mean_max_stats: drives sample and clear words, checks every
// statistics word against an in-bench window predictor. Depends on swms_pkg and the
// swms_in_if / swms_out_if channel interfaces.

module tb_top;
  import swms_pkg::*;

  localparam int RANDOM_WORDS = 800;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;

  typedef struct packed {
    sample_t          mean_a;
    sample_t          mean_b;
    peak_t            peak_a;
    peak_t            peak_b;
    peak_t            peak_c;
    peak_t            peak_d;
    sample_t          latest_a;
    sample_t          latest_b;
    sample_t          latest_c;
    sample_t          latest_d;
    logic [CNT_W-1:0] fill_count;
  } stats_t;

  class window_stats_model;
    sample_t ring [WINDOW_MAX][NUM_CH];
    int      wr_ptr;
    int      fill;
    int      win_len;
    int      errors;
    stats_t  expected_stats [$];

    function new();
      wr_ptr  = 0;
      fill    = 0;
      win_len = WINDOW_RESET;
      errors  = 0;
    endfunction

    function void set_window(logic [CNT_W-1:0] v);
      win_len = v;
    endfunction

    function int pending();
      return expected_stats.size();
    endfunction

    function void note_word(logic op, sample_t a, sample_t b, sample_t c, sample_t d);
      stats_t st;
      int     eff;
      int     sum_a;
      int     sum_b;
      int     idx;
      int     peak [NUM_CH];
      st = '0;
      if (op == OP_CLEAR) begin
        wr_ptr = 0;
        fill   = 0;
        expected_stats = {expected_stats, st};
        return;
      end
      ring[wr_ptr][0] = a;
      ring[wr_ptr][1] = b;
      ring[wr_ptr][2] = c;
      ring[wr_ptr][3] = d;
      wr_ptr = (wr_ptr + 1) % WINDOW_MAX;
      eff = (win_len < 1) ? 1 : (win_len > WINDOW_MAX) ? WINDOW_MAX : win_len;
      if (fill < eff) fill++;
      else fill = eff;
      sum_a = 0;
      sum_b = 0;
      foreach (peak[ch]) peak[ch] = 0;
      for (int i = 0; i < fill; i++) begin
        idx = (wr_ptr + 2 * WINDOW_MAX - 1 - i) % WINDOW_MAX;
        sum_a += int'(ring[idx][0]);
        sum_b += int'(ring[idx][1]);
        for (int ch = 0; ch < NUM_CH; ch++) begin
          if (int'(ring[idx][ch]) > peak[ch]) peak[ch] = int'(ring[idx][ch]);
        end
      end
      st.mean_a     = sample_t'(sum_a / fill);
      st.mean_b     = sample_t'(sum_b / fill);
      st.peak_a     = peak_t'(peak[0]);
      st.peak_b     = peak_t'(peak[1]);
      st.peak_c     = peak_t'(peak[2]);
      st.peak_d     = peak_t'(peak[3]);
      st.latest_a   = a;
      st.latest_b   = b;
      st.latest_c   = c;
      st.latest_d   = d;
      st.fill_count = CNT_W'(fill);
      expected_stats = {expected_stats, st};
    endfunction

    function void cmp(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_word(stats_t got);
      stats_t want;
      if (expected_stats.size() == 0) begin
        errors++;
        $display("%0t: stats word with none pending, expected none actual fill %0d",
                 $time, got.fill_count);
        return;
      end
      want = expected_stats.pop_front();
      cmp("mean_a", want.mean_a, got.mean_a);
      cmp("mean_b", want.mean_b, got.mean_b);
      cmp("peak_a", want.peak_a, got.peak_a);
      cmp("peak_b", want.peak_b, got.peak_b);
      cmp("peak_c", want.peak_c, got.peak_c);
      cmp("peak_d", want.peak_d, got.peak_d);
      cmp("latest_a", want.latest_a, got.latest_a);
      cmp("latest_b", want.latest_b, got.latest_b);
      cmp("latest_c", want.latest_c, got.latest_c);
      cmp("latest_d", want.latest_d, got.latest_d);
      cmp("fill_count", want.fill_count, got.fill_count);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  bit   hold_off_req = 1'b0;
  int   random_words = 0;

  window_stats_model sb;

  swms_in_if  in_ch ();
  swms_out_if out_ch ();

  sliding_window_mean_max_stats dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    stats_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.mean_a     = out_ch.mean_a;
      got.mean_b     = out_ch.mean_b;
      got.peak_a     = out_ch.peak_a;
      got.peak_b     = out_ch.peak_b;
      got.peak_c     = out_ch.peak_c;
      got.peak_d     = out_ch.peak_d;
      got.latest_a   = out_ch.latest_a;
      got.latest_b   = out_ch.latest_b;
      got.latest_c   = out_ch.latest_c;
      got.latest_d   = out_ch.latest_d;
      got.fill_count = out_ch.fill_count;
      sb.check_word(got);
    end
  end

  // receiver: stall patterns, plus one long hold-off on request
  initial begin
    int mode;
    int len;
    logic rdy;
    out_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(20, 200);
      for (int k = 0; k < len; k++) begin
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0: rdy = 1'b1;
          1: rdy = ($urandom_range(0, 3) != 0);
          2: rdy = (k % 5 == 0);
          default: rdy = $urandom_range(0, 1);
        endcase
        out_ch.ready <= rdy;
        @(posedge clk);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 5))
      0, 1: return sample_t'($urandom);
      2: begin
        case ($urandom_range(0, 4))
          0: return sample_t'(32767);
          1: return sample_t'(-32768);
          2: return sample_t'(0);
          3: return sample_t'(-1);
          default: return sample_t'(1);
        endcase
      end
      3: return sample_t'(int'($urandom_range(0, 1023)) - 512);
      4: return sample_t'($urandom_range(0, 32767));
      default: return sample_t'(-int'($urandom_range(1, 32768)));
    endcase
  endfunction

  task automatic send_word(logic op, sample_t a, sample_t b, sample_t c, sample_t d);
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.sample_a <= a;
    in_ch.sample_b <= b;
    in_ch.sample_c <= c;
    in_ch.sample_d <= d;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_word(op, a, b, c, d);
  endtask

  task automatic send_random_word();
    logic op;
    op = ($urandom_range(0, 24) == 0) ? OP_CLEAR : OP_RECORD;
    send_word(op, pick_sample(), pick_sample(), pick_sample(), pick_sample());
    random_words++;
  endtask

  task automatic gap(int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_window(int v);
    drain();
    repeat (8) @(posedge clk);
    cfg_wdata <= CNT_W'(v);
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_window(CNT_W'(v));
  endtask

  task automatic run_words(int n, int hold_at, int pause_at);
    int burst_left;
    burst_left = 0;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_off_req = 1'b1;
      if (i == pause_at) drain();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
      end
      send_random_word();
      burst_left--;
    end
  endtask

  initial begin
    int win;
    int eff;
    int n;
    int phase;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = OP_RECORD;
    in_ch.sample_a = '0;
    in_ch.sample_b = '0;
    in_ch.sample_c = '0;
    in_ch.sample_d = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    rst_n          = 1'b0;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: clear on empty, extremes, negative-only peaks, truncation toward zero
    send_word(OP_CLEAR, -32768, 32767, -1, 12345);
    send_word(OP_RECORD, 32767, -32768, 0, -1);
    send_word(OP_RECORD, -32768, 32767, 32767, -32768);
    send_word(OP_RECORD, -1, -1, -1, -1);
    send_word(OP_CLEAR, 0, 0, 0, 0);
    send_word(OP_RECORD, -3, -3, -32768, -32768);
    send_word(OP_RECORD, -2, 5, -7, -1);
    send_word(OP_RECORD, 1, 1, 1, 1);
    write_window(1);
    send_word(OP_RECORD, 100, -100, 200, -200);
    send_word(OP_RECORD, -5, 5, -5, 5);
    send_word(OP_RECORD, 32767, 32767, 32767, 32767);
    write_window(0);
    send_word(OP_RECORD, -32768, -32768, -32768, -32768);
    send_word(OP_RECORD, 7, 8, 9, 10);
    // grow without a clear: older ring entries rejoin
    write_window(127);
    send_word(OP_RECORD, 3, 3, 3, 3);
    send_word(OP_RECORD, -9, 4, 0, 2);
    send_word(OP_RECORD, 11, -11, 22, -22);
    // shrink without a clear: excess oldest entries drop at once
    write_window(2);
    send_word(OP_RECORD, 1000, -1000, 500, -500);
    send_word(OP_CLEAR, 1, 2, 3, 4);

    phase = 0;
    while (random_words < RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0: win = WINDOW_MAX;
        1: win = 127;
        2: win = 0;
        3: win = 1;
        4, 5, 6: win = $urandom_range(2, 8);
        7, 8: win = $urandom_range(9, 40);
        default: win = $urandom_range(41, 126);
      endcase
      if (phase == 0) win = WINDOW_MAX;
      eff = (win < 1) ? 1 : (win > WINDOW_MAX) ? WINDOW_MAX : win;
      write_window(win);
      if ($urandom_range(0, 3) != 0) send_word(OP_CLEAR, pick_sample(), pick_sample(),
                                               pick_sample(), pick_sample());
      n = (eff >= 40) ? $urandom_range(70, 110) : $urandom_range(8, 40);
      run_words(n, (phase == 0) ? 10 : -1, (phase == 1) ? 5 : -1);
      phase++;
    end

    drain();
    repeat (120) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/swms_pkg.sv
rtl/swms_in_if.sv
rtl/swms_out_if.sv
rtl/swms_ctrl.sv
rtl/swms_dp.sv
rtl/sliding_window_mean_max_stats.sv
sim/tb_top.sv
